// File: rtl/core/gsg_pkg.sv
// ----------------------------------------------------------------------------
// gsg_pkg
// Shared widths, register indexes and the 5x7 column font for the glyph
// stroke generator.
// ----------------------------------------------------------------------------
package gsg_pkg;

  localparam int unsigned CFG_W   = 18;  // configuration data width
  localparam int unsigned CIDX_W  = 3;   // configuration index width
  localparam int unsigned COORD_W = 18;  // bed coordinate width
  localparam int unsigned ORG_W   = 19;  // local origin width
  localparam int unsigned CELL_W  = 11;

  localparam logic [CIDX_W-1:0] REG_CELL_SIZE    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FONT_STYLE   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ROTATION     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_MIRROR       = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BLOCK_WIDTH  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_BLOCK_HEIGHT = 3'd5;
  localparam logic [CIDX_W-1:0] REG_BED_WIDTH    = 3'd6;
  localparam logic [CIDX_W-1:0] REG_BED_HEIGHT   = 3'd7;

  localparam logic [1:0] STYLE_VECTOR  = 2'd0;
  localparam logic [1:0] STYLE_BLOCK   = 2'd1;
  localparam logic [1:0] STYLE_OUTLINE = 2'd2;
  localparam logic [1:0] STYLE_ITALIC  = 2'd3;

  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;

  localparam int unsigned GLYPHS = 59;

  // Each entry holds columns 0..4 from the most significant byte down;
  // bit 0 of a column is the top row.
  localparam logic [0:GLYPHS-1][39:0] GLYPH_ROM = {
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543
  };

endpackage

// File: rtl/core/glyph_stroke_generator_unit.sv
// ----------------------------------------------------------------------------
// glyph_stroke_generator_unit
// 5x7 stroke character generator: turns one character request into line or
// square shapes in clamped bed coordinates.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the last shape of the character has been produced. A space is taken
// and gives no shapes, and busy stays low. A small sequencer first runs the
// rounding divide (S_DIV_MUL, S_DIV_FIX), then visits one font pixel per
// cycle while it is not held: column by column for the outline style, or row
// by row for the other styles, each row opened by a setup state (S_ROW) and
// scanned one column past the glyph. A copy state holds the scan for each
// copied block line, italic repeats the divide per row for the slant, and a
// final state flushes the held shape. The next request can be taken in the
// first cycle that busy is low. Shapes leave one per strobe on out_valid, one
// shape behind the scan; the final shape comes in the first idle cycle.
// Results cannot be held off by the receiver.
module glyph_stroke_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [7:0]                         in_char_code,
  input  logic signed [gsg_pkg::ORG_W-1:0]   in_origin_x,
  input  logic signed [gsg_pkg::ORG_W-1:0]   in_origin_y,
  input  logic                               cfg_we,
  input  logic [gsg_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [gsg_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic                               out_shape_kind,
  output logic [gsg_pkg::COORD_W-1:0]        out_start_x,
  output logic [gsg_pkg::COORD_W-1:0]        out_start_y,
  output logic [gsg_pkg::COORD_W-1:0]        out_end_x,
  output logic [gsg_pkg::COORD_W-1:0]        out_end_y,
  output logic                               out_last_shape
);

  localparam int unsigned LW = 22;  // local coordinate width
  localparam int unsigned TW = 26;  // doubled transform width
  localparam int unsigned CW = gsg_pkg::COORD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_MUL, S_DIV_FIX, S_ROW, S_SCAN, S_COPY, S_OUTL, S_FLUSH
  } state_t;

  typedef struct packed {
    logic                 kind;
    logic signed [LW-1:0] x1;
    logic signed [LW-1:0] y1;
    logic signed [LW-1:0] x2;
    logic signed [LW-1:0] y2;
  } shape_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } bed_pt_t;

  state_t               state_r, state_nxt;
  logic [10:0]          cell_r;
  logic [1:0]           style_r, rot_r;
  logic                 mir_r;
  logic [CW-1:0]        bw_r, bh_r, bedw_r, bedh_r;
  logic [4:0][6:0]      glyph_r, glyph_nxt;
  logic signed [LW-1:0] ox_r, ox_nxt, xcol_r, xcol_nxt, yrow_r, yrow_nxt;
  logic signed [LW-1:0] xstart_r, xstart_nxt;
  logic [2:0]           col_r, col_nxt, row_r, row_nxt;
  logic                 run_r, run_nxt;
  logic [8:0]           shift_r, shift_nxt;
  logic [10:0]          side_r, side_nxt;
  logic [11:0]          slant_r, slant_nxt;
  logic [18:0]          div_num_r, div_num_nxt;
  logic [34:0]          div_prod_r, div_prod_nxt;
  logic                 div_row_r, div_row_nxt;
  logic                 pend_v_r, pend_v_nxt;
  shape_t               pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic                 out_last_r, out_last_nxt;
  bed_pt_t              out_p1_r, out_p1_nxt, out_p2_r, out_p2_nxt;

  logic                 push_v;
  shape_t               push_s;
  logic [7:0]           ch_fold;
  logic [5:0]           rom_ix;
  logic [39:0]          rom_word;
  logic [12:0]          q0;
  logic [19:0]          rem;
  logic [11:0]          q;
  logic [2:0]           col_ix;
  logic                 pix_on;
  logic signed [LW-1:0] cell_s, half_s, slant_s, side_s, shift_s, yy;
  logic [7:0]           slant_k;

  function automatic bed_pt_t to_bed(input logic signed [LW-1:0] lx,
                                     input logic signed [LW-1:0] ly);
    logic signed [TW-1:0] rx, ry, tx, ty, vx, vy, limx, limy;
    bed_pt_t p;
    rx = (TW'(lx) <<< 1) - $signed({{(TW-CW){1'b0}}, bw_r});
    ry = $signed({{(TW-CW){1'b0}}, bh_r}) - (TW'(ly) <<< 1);
    if (mir_r) begin
      rx = -rx;
    end
    case (rot_r)
      2'd1: begin tx = -ry; ty = rx;  end
      2'd2: begin tx = -rx; ty = -ry; end
      2'd3: begin tx = ry;  ty = -rx; end
      default: begin tx = rx; ty = ry; end
    endcase
    limx = $signed({{(TW-CW){1'b0}}, bedw_r});
    limy = $signed({{(TW-CW){1'b0}}, bedh_r});
    vx = limx + tx;
    vy = limy + ty;
    if (vx < 0) vx = '0;
    else if (vx > (limx <<< 1)) vx = limx <<< 1;
    if (vy < 0) vy = '0;
    else if (vy > (limy <<< 1)) vy = limy <<< 1;
    p.x = vx[CW:1];
    p.y = vy[CW:1];
    return p;
  endfunction

  assign cell_s  = $signed({{(LW-11){1'b0}}, cell_r});
  assign half_s  = $signed({{(LW-10){1'b0}}, cell_r[10:1]});
  assign slant_s = $signed({{(LW-12){1'b0}}, slant_r});
  assign side_s  = $signed({{(LW-11){1'b0}}, side_r});
  assign shift_s = $signed({{(LW-9){1'b0}}, shift_r});
  assign yy      = yrow_r + half_s;
  assign col_ix  = (col_r < 3'd5) ? col_r : 3'd0;
  assign pix_on  = (col_r < 3'd5) && glyph_r[col_ix][row_r];
  assign slant_k = 8'(3'd6 - row_r) * 8'd24;

  always_comb begin
    ch_fold = in_char_code;
    if (in_char_code >= 8'h61 && in_char_code <= 8'h7A) begin
      ch_fold = in_char_code - 8'd32;
    end
    if (ch_fold < gsg_pkg::CHAR_SPACE || ch_fold > 8'h5A) begin
      ch_fold = gsg_pkg::CHAR_QUESTION;
    end
    rom_ix   = 6'(ch_fold - gsg_pkg::CHAR_SPACE);
    rom_word = gsg_pkg::GLYPH_ROM[rom_ix];
  end

  // Division by 100: the reciprocal product is at most one short.
  always_comb begin
    q0  = div_prod_r[34:22];
    rem = {1'b0, div_num_r} - 20'(q0) * 20'd100;
    q   = (rem >= 20'd100) ? 12'(q0 + 13'd1) : q0[11:0];
  end

  always_comb begin
    state_nxt    = state_r;
    glyph_nxt    = glyph_r;
    ox_nxt       = ox_r;
    xcol_nxt     = xcol_r;
    yrow_nxt     = yrow_r;
    xstart_nxt   = xstart_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    run_nxt      = run_r;
    shift_nxt    = shift_r;
    side_nxt     = side_r;
    slant_nxt    = slant_r;
    div_num_nxt  = div_num_r;
    div_prod_nxt = div_prod_r;
    div_row_nxt  = div_row_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt = out_kind_r;
    out_last_nxt = 1'b0;
    out_p1_nxt   = out_p1_r;
    out_p2_nxt   = out_p2_r;
    push_v       = 1'b0;
    push_s       = pend_r;

    case (state_r)
      S_IDLE: begin
        if (start && in_char_code != gsg_pkg::CHAR_SPACE) begin
          for (int i = 0; i < 5; i++) begin
            glyph_nxt[i] = rom_word[38-8*i -: 7];
          end
          ox_nxt   = LW'(in_origin_x);
          xcol_nxt = LW'(in_origin_x);
          yrow_nxt = LW'(in_origin_y);
          col_nxt  = '0;
          row_nxt  = '0;
          run_nxt  = 1'b0;
          div_row_nxt = 1'b0;
          div_num_nxt = (style_r == gsg_pkg::STYLE_OUTLINE)
                      ? 19'(cell_r) * 19'd82 + 19'd50
                      : 19'(cell_r) * 19'd16 + 19'd50;
          state_nxt = S_DIV_MUL;
        end
      end
      S_DIV_MUL: begin
        div_prod_nxt = div_num_r * 16'd41943;
        state_nxt    = S_DIV_FIX;
      end
      S_DIV_FIX: begin
        if (div_row_r) begin
          slant_nxt = q;
          state_nxt = S_SCAN;
        end else begin
          side_nxt  = q[10:0];
          shift_nxt = (style_r == gsg_pkg::STYLE_BLOCK) ? q[8:0] : '0;
          state_nxt = (style_r == gsg_pkg::STYLE_OUTLINE) ? S_OUTL : S_ROW;
        end
      end
      S_ROW: begin
        col_nxt  = '0;
        run_nxt  = 1'b0;
        xcol_nxt = ox_r;
        if (style_r == gsg_pkg::STYLE_ITALIC) begin
          div_num_nxt = 19'(slant_k) * 19'(cell_r) + 19'd50;
          div_row_nxt = 1'b1;
          state_nxt   = S_DIV_MUL;
        end else begin
          slant_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        col_nxt  = col_r + 3'd1;
        xcol_nxt = xcol_r + cell_s;
        if (pix_on && !run_r) begin
          run_nxt    = 1'b1;
          xstart_nxt = xcol_r;
        end else if (!pix_on && run_r) begin
          run_nxt     = 1'b0;
          push_v      = 1'b1;
          push_s.kind = 1'b0;
          push_s.x1   = xstart_r + slant_s;
          push_s.x2   = xcol_r + slant_s;
          push_s.y1   = yy;
          push_s.y2   = yy;
        end
        if (push_v && shift_r != '0) begin
          state_nxt = S_COPY;
        end else if (col_r == 3'd5) begin
          row_nxt  = row_r + 3'd1;
          yrow_nxt = yrow_r + cell_s;
          state_nxt = (row_r == 3'd6) ? S_FLUSH : S_ROW;
        end
      end
      S_COPY: begin
        push_v    = 1'b1;
        push_s.y1 = pend_r.y1 + shift_s;
        push_s.y2 = pend_r.y2 + shift_s;
        if (col_r == 3'd6) begin
          row_nxt  = row_r + 3'd1;
          yrow_nxt = yrow_r + cell_s;
          state_nxt = (row_r == 3'd6) ? S_FLUSH : S_ROW;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_OUTL: begin
        if (glyph_r[col_ix][row_r]) begin
          push_v      = 1'b1;
          push_s.kind = 1'b1;
          push_s.x1   = xcol_r;
          push_s.y1   = yrow_r;
          push_s.x2   = xcol_r + side_s;
          push_s.y2   = yrow_r + side_s;
        end
        if (row_r == 3'd6) begin
          row_nxt  = '0;
          yrow_nxt = yrow_r - 22'(6) * cell_s;
          col_nxt  = col_r + 3'd1;
          xcol_nxt = xcol_r + cell_s;
          if (col_r == 3'd4) begin
            state_nxt = S_FLUSH;
          end
        end else begin
          row_nxt  = row_r + 3'd1;
          yrow_nxt = yrow_r + cell_s;
        end
      end
      S_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_kind_nxt  = pend_r.kind;
          out_p1_nxt    = to_bed(pend_r.x1, pend_r.y1);
          out_p2_nxt    = to_bed(pend_r.x2, pend_r.y2);
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // One shape is held back so that the final one can carry the last flag.
    if (push_v) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_r.kind;
        out_p1_nxt    = to_bed(pend_r.x1, pend_r.y1);
        out_p2_nxt    = to_bed(pend_r.x2, pend_r.y2);
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = push_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      cell_r      <= 11'd658;
      style_r     <= gsg_pkg::STYLE_VECTOR;
      rot_r       <= '0;
      mir_r       <= 1'b0;
      bw_r        <= '0;
      bh_r        <= '0;
      bedw_r      <= 18'd51200;
      bedh_r      <= 18'd51200;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gsg_pkg::REG_CELL_SIZE:    cell_r  <= cfg_data[10:0];
          gsg_pkg::REG_FONT_STYLE:   style_r <= cfg_data[1:0];
          gsg_pkg::REG_ROTATION:     rot_r   <= cfg_data[1:0];
          gsg_pkg::REG_MIRROR:       mir_r   <= cfg_data[0];
          gsg_pkg::REG_BLOCK_WIDTH:  bw_r    <= cfg_data;
          gsg_pkg::REG_BLOCK_HEIGHT: bh_r    <= cfg_data;
          gsg_pkg::REG_BED_WIDTH:    bedw_r  <= cfg_data;
          gsg_pkg::REG_BED_HEIGHT:   bedh_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    glyph_r    <= glyph_nxt;
    ox_r       <= ox_nxt;
    xcol_r     <= xcol_nxt;
    yrow_r     <= yrow_nxt;
    xstart_r   <= xstart_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    run_r      <= run_nxt;
    shift_r    <= shift_nxt;
    side_r     <= side_nxt;
    slant_r    <= slant_nxt;
    div_num_r  <= div_num_nxt;
    div_prod_r <= div_prod_nxt;
    div_row_r  <= div_row_nxt;
    pend_r     <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_p1_r   <= out_p1_nxt;
    out_p2_r   <= out_p2_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_shape_kind = out_kind_r;
  assign out_start_x    = out_p1_r.x;
  assign out_start_y    = out_p1_r.y;
  assign out_end_x      = out_p2_r.x;
  assign out_end_y      = out_p2_r.y;
  assign out_last_shape = out_last_r;

endmodule

// File: rtl/core/gsg_checker.sv
// ----------------------------------------------------------------------------
// gsg_checker
// Port-level checks on request and result timing of the stroke generator.
// ----------------------------------------------------------------------------
module gsg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [7:0]                        in_char_code,
  input logic                              out_valid,
  input logic                              out_last_shape
);

  // Any request other than a space always starts work.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_char_code != gsg_pkg::CHAR_SPACE) |=> busy)
    else $error("request did not start work");

  // Only the final shape of a character may appear once the block is idle.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_shape) |-> busy)
    else $error("non-final shape while idle");

  // The final shape is never directly followed by another result.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_shape) |=> !out_valid)
    else $error("result right after final shape");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity right after reset");

endmodule

bind glyph_stroke_generator_unit gsg_checker u_gsg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_char_code   (in_char_code),
  .out_valid      (out_valid),
  .out_last_shape (out_last_shape)
);
